[hdl/tpri_pkg.sv]
// Shared widths, register codes and reset values for the tile picker.
`default_nettype none

package tpri_pkg;

    localparam int POS_W      = 20;
    localparam int FRAC_BITS  = 4;
    localparam int DIFF_W     = POS_W + 1;
    localparam int MAG_W      = POS_W;
    localparam int TSIZE_W    = 10;
    localparam int SIZE_W     = TSIZE_W + FRAC_BITS;
    localparam int CNT_W      = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int TIDX_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = MAG_W / DIV_BITS;

    localparam logic [CNT_W-1:0] MAX_COLS = CNT_W'(1024);
    localparam logic [CNT_W-1:0] MAX_ROWS = CNT_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_MODE  = 3'd0,
        REG_TILE_WIDTH  = 3'd1,
        REG_TILE_HEIGHT = 3'd2,
        REG_COUNT_COLS  = 3'd3,
        REG_COUNT_ROWS  = 3'd4,
        REG_ORIGIN_X    = 3'd5,
        REG_ORIGIN_Y    = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        SHAPE_RECT = 1'b0,
        SHAPE_ISO  = 1'b1
    } shape_t;

    localparam logic [TSIZE_W-1:0] RST_TILE_WIDTH  = TSIZE_W'(160);
    localparam logic [TSIZE_W-1:0] RST_TILE_HEIGHT = TSIZE_W'(80);
    localparam logic [CNT_W-1:0]   RST_COUNT_COLS  = CNT_W'(1);
    localparam logic [CNT_W-1:0]   RST_COUNT_ROWS  = CNT_W'(1);

endpackage

`default_nettype wire

[hdl/tpri_query_if.sv]
// Query channel: one world position per transaction.
`default_nettype none

interface tpri_query_if;
    import tpri_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

[hdl/tpri_result_if.sv]
// Result channel: tile hit, column, row and linear index per transaction.
`default_nettype none

interface tpri_result_if;
    import tpri_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [TIDX_W-1:0] tile_index;

    modport source (output valid, output hit, output col, output row, output tile_index,
                    input ready);
    modport sink   (input valid, input hit, input col, input row, input tile_index,
                    output ready);
endinterface

`default_nettype wire

[hdl/tpri_div.sv]
// Pipelined signed floor divider by an unsigned tile size, a few quotient bits per stage.
`default_nettype none

module tpri_div
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [tpri_pkg::DIFF_W-1:0]  dividend,
    input  logic        [tpri_pkg::SIZE_W-1:0]  divisor,
    output logic signed [tpri_pkg::DIFF_W-1:0]  quotient,
    output logic        [tpri_pkg::SIZE_W-1:0]  remainder
);
    import tpri_pkg::*;

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  num;
        logic [MAG_W-1:0]  quo;
        logic [SIZE_W-1:0] rem;
    } div_stage_t;

    div_stage_t stage_in   [DIV_STAGES];
    div_stage_t stage_next [DIV_STAGES];
    div_stage_t stage_reg  [DIV_STAGES];
    div_stage_t last;

    function automatic div_stage_t div_step(input div_stage_t s, input logic [SIZE_W-1:0] d);
        div_stage_t      o;
        logic [SIZE_W:0] t;
        o = s;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            t     = {o.rem, o.num[MAG_W-1]};
            o.num = {o.num[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t     = t - {1'b0, d};
                o.quo = {o.quo[MAG_W-2:0], 1'b1};
            end
            else
            begin
                o.quo = {o.quo[MAG_W-2:0], 1'b0};
            end
            o.rem = t[SIZE_W-1:0];
        end
        return o;
    endfunction

    // negative dividends divide their one's complement; fixed up at the output
    always_comb
    begin
        stage_in[0].neg = dividend[DIFF_W-1];
        stage_in[0].num = dividend[DIFF_W-1] ? ~dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
        stage_in[0].quo = '0;
        stage_in[0].rem = '0;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stage_in[s] = stage_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stage_next[s] = div_step(stage_in[s], divisor);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign last      = stage_reg[DIV_STAGES-1];
    assign quotient  = last.neg ? {1'b1, ~last.quo} : {1'b0, last.quo};
    assign remainder = last.neg ? (divisor - SIZE_W'(1) - last.rem) : last.rem;

endmodule

`default_nettype wire

[hdl/tile_pick_rect_or_isometric_top.sv]
// Tile picker top level: config registers, floor dividers and the pick pipeline.
//
// Usage:
//   query  : one world position (pos_x, pos_y, signed, 4 fraction bits) per transaction.
//   result : hit, col, row, tile_index for that position, in query order.
//   cfg_*  : write port for the seven map registers; write only while the block is idle.
// Timing:
//   12 register stages: input, five divider stages (4 quotient bits each), remainder
//   fixup, size products, diamond edge compares, row/column select, index product,
//   output. Throughput is one transaction per cycle when the receiver does not stall.
// Reset:
//   Registers return to rectangular mode, 160x80 tiles, a 1x1 map at origin 0.
//   The pipeline empties and no result is valid.
// Backpressure:
//   While the output register holds a result that is not taken, the whole pipeline
//   holds and query.ready is low; nothing is dropped or repeated.
`default_nettype none

module tile_pick_rect_or_isometric_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tpri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpri_pkg::CFG_DATA_W-1:0]      cfg_data,
    tpri_query_if.sink                           query,
    tpri_result_if.source                        result
);
    import tpri_pkg::*;

    localparam int PIPE_DEPTH = DIV_STAGES + 7;
    localparam int PROD_W     = 2 * SIZE_W + 1;
    localparam int CMP_W      = PROD_W + 2;
    localparam int CAND_W     = DIFF_W + 2;

    // configuration
    shape_t                     shape_mode_reg;
    logic [TSIZE_W-1:0]         tile_width_reg;
    logic [TSIZE_W-1:0]         tile_height_reg;
    logic [CNT_W-1:0]           count_cols_reg;
    logic [CNT_W-1:0]           count_rows_reg;
    logic signed [POS_W-1:0]    origin_x_reg;
    logic signed [POS_W-1:0]    origin_y_reg;

    logic [SIZE_W-1:0]          w_size;
    logic [SIZE_W-1:0]          h_size;
    logic [CNT_W-1:0]           cols_eff;
    logic [CNT_W-1:0]           rows_eff;
    logic                       cfg_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg  <= SHAPE_RECT;
            tile_width_reg  <= RST_TILE_WIDTH;
            tile_height_reg <= RST_TILE_HEIGHT;
            count_cols_reg  <= RST_COUNT_COLS;
            count_rows_reg  <= RST_COUNT_ROWS;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SHAPE_MODE:  shape_mode_reg  <= shape_t'(cfg_data[0]);
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TSIZE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[TSIZE_W-1:0];
                REG_COUNT_COLS:  count_cols_reg  <= cfg_data[CNT_W-1:0];
                REG_COUNT_ROWS:  count_rows_reg  <= cfg_data[CNT_W-1:0];
                REG_ORIGIN_X:    origin_x_reg    <= $signed(cfg_data[POS_W-1:0]);
                REG_ORIGIN_Y:    origin_y_reg    <= $signed(cfg_data[POS_W-1:0]);
                default:         ;
            endcase
        end
    end

    assign w_size   = {tile_width_reg, {FRAC_BITS{1'b0}}};
    assign h_size   = {tile_height_reg, {FRAC_BITS{1'b0}}};
    assign cols_eff = (count_cols_reg > MAX_COLS) ? MAX_COLS : count_cols_reg;
    assign rows_eff = (count_rows_reg > MAX_ROWS) ? MAX_ROWS : count_rows_reg;
    assign cfg_ok   = (tile_width_reg != '0) && (tile_height_reg != '0)
                      && (cols_eff != '0) && (rows_eff != '0);

    // pipeline control
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  advance;

    assign advance     = !valid_reg[PIPE_DEPTH-1] || result.ready;
    assign query.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], query.valid};
        end
    end

    // input stage: offsets from the map origin
    logic signed [DIFF_W-1:0] dx_reg, dx_next;
    logic signed [DIFF_W-1:0] dy_reg, dy_next;

    assign dx_next = {query.pos_x[POS_W-1], query.pos_x} - {origin_x_reg[POS_W-1], origin_x_reg};
    assign dy_next = {query.pos_y[POS_W-1], query.pos_y} - {origin_y_reg[POS_W-1], origin_y_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // floor division on both axes
    logic signed [DIFF_W-1:0] qx, qy;
    logic [SIZE_W-1:0]        rx, ry;

    tpri_div u_div_x
    (
        .clk       (clk),
        .en        (advance),
        .dividend  (dx_reg),
        .divisor   (w_size),
        .quotient  (qx),
        .remainder (rx)
    );

    tpri_div u_div_y
    (
        .clk       (clk),
        .en        (advance),
        .dividend  (dy_reg),
        .divisor   (h_size),
        .quotient  (qy),
        .remainder (ry)
    );

    // cell stage
    logic signed [DIFF_W-1:0] ix_f_reg, iy_f_reg;
    logic [SIZE_W-1:0]        rx_f_reg, ry_f_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ix_f_reg <= qx;
            iy_f_reg <= qy;
            rx_f_reg <= rx;
            ry_f_reg <= ry;
        end
    end

    // product stage: scaled in-cell fraction against the diamond edges
    logic [2*SIZE_W-1:0]      ry_w, rx_h, w_h;
    logic [PROD_W-1:0]        a_reg, b_reg, p_reg;
    logic                     lower_m_reg, upper_m_reg, rx_half_m_reg;
    logic signed [DIFF_W-1:0] ix_m_reg, iy_m_reg;

    assign ry_w = (2*SIZE_W)'(ry_f_reg) * (2*SIZE_W)'(w_size);
    assign rx_h = (2*SIZE_W)'(rx_f_reg) * (2*SIZE_W)'(h_size);
    assign w_h  = (2*SIZE_W)'(w_size) * (2*SIZE_W)'(h_size);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg         <= {ry_w, 1'b0};
            b_reg         <= {rx_h, 1'b0};
            p_reg         <= {1'b0, w_h};
            lower_m_reg   <= {ry_f_reg, 1'b0} < {1'b0, h_size};
            upper_m_reg   <= {ry_f_reg, 1'b0} > {1'b0, h_size};
            rx_half_m_reg <= {rx_f_reg, 1'b0} >= {1'b0, w_size};
            ix_m_reg      <= ix_f_reg;
            iy_m_reg      <= iy_f_reg;
        end
    end

    // compare stage
    logic [CMP_W-1:0]         a_ext, b_ext, p_ext, ab_sum;
    logic                     c_lo_left_reg, c_lo_right_reg, c_up_left_reg, c_up_right_reg;
    logic                     lower_c_reg, upper_c_reg, rx_half_c_reg;
    logic signed [DIFF_W-1:0] ix_c_reg, iy_c_reg;

    assign a_ext  = CMP_W'(a_reg);
    assign b_ext  = CMP_W'(b_reg);
    assign p_ext  = CMP_W'(p_reg);
    assign ab_sum = a_ext + b_ext;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_lo_left_reg  <= ab_sum < p_ext;
            c_lo_right_reg <= (a_ext + p_ext) < b_ext;
            c_up_left_reg  <= a_ext > (b_ext + p_ext);
            c_up_right_reg <= ab_sum > (p_ext + {p_ext[CMP_W-2:0], 1'b0});
            lower_c_reg    <= lower_m_reg;
            upper_c_reg    <= upper_m_reg;
            rx_half_c_reg  <= rx_half_m_reg;
            ix_c_reg       <= ix_m_reg;
            iy_c_reg       <= iy_m_reg;
        end
    end

    // select stage: row and column, map range checks
    logic signed [CAND_W-1:0] ix_ext, iy_ext, iy2, row_dn, row_up;
    logic signed [CAND_W-1:0] cols_s, rows_s, row_c, col_c;
    logic                     ix_out, ix_zero, iy_zero, ix_ge_cols, top_out;
    logic                     miss, hit_s_next;
    logic                     hit_s_reg;
    logic [COL_W-1:0]         col_s_reg;
    logic [ROW_W-1:0]         row_s_reg;

    always_comb
    begin
        ix_ext     = {{2{ix_c_reg[DIFF_W-1]}}, ix_c_reg};
        iy_ext     = {{2{iy_c_reg[DIFF_W-1]}}, iy_c_reg};
        iy2        = {iy_c_reg[DIFF_W-1], iy_c_reg, 1'b0};
        row_dn     = iy2 - CAND_W'(1);
        row_up     = iy2 + CAND_W'(1);
        cols_s     = {{(CAND_W-CNT_W){1'b0}}, cols_eff};
        rows_s     = {{(CAND_W-CNT_W){1'b0}}, rows_eff};
        ix_out     = ix_ext[CAND_W-1] || (ix_ext > cols_s);
        ix_zero    = (ix_c_reg == '0);
        iy_zero    = (iy_c_reg == '0);
        ix_ge_cols = (ix_ext >= cols_s);
        top_out    = (row_up >= rows_s);
        miss       = 1'b0;
        row_c      = iy2;

        if (shape_mode_reg == SHAPE_RECT)
        begin
            row_c = iy_ext;
        end
        else
        begin
            priority if (ix_out)
            begin
                miss = 1'b1;
            end
            else if (lower_c_reg)
            begin
                priority if (c_lo_left_reg)
                begin
                    row_c = row_dn;
                    miss  = iy_zero || ix_zero;
                end
                else if (c_lo_right_reg)
                begin
                    row_c = row_dn;
                    miss  = iy_zero;
                end
                else
                begin
                    row_c = iy2;
                end
            end
            else if (upper_c_reg)
            begin
                priority if (c_up_left_reg)
                begin
                    row_c = row_up;
                    miss  = ix_zero || top_out;
                end
                else if (c_up_right_reg)
                begin
                    row_c = row_up;
                    miss  = ix_ge_cols || top_out;
                end
                else
                begin
                    row_c = iy2;
                end
            end
            else
            begin
                row_c = iy2;
            end
        end

        // odd rows sit half a tile to the right
        if ((shape_mode_reg == SHAPE_ISO) && row_c[0] && !rx_half_c_reg)
        begin
            col_c = ix_ext - CAND_W'(1);
        end
        else
        begin
            col_c = ix_ext;
        end

        hit_s_next = cfg_ok && !miss
                     && !row_c[CAND_W-1] && (row_c < rows_s)
                     && !col_c[CAND_W-1] && (col_c < cols_s);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_s_reg <= hit_s_next;
            col_s_reg <= hit_s_next ? col_c[COL_W-1:0] : '0;
            row_s_reg <= hit_s_next ? row_c[ROW_W-1:0] : '0;
        end
    end

    // index product stage
    logic [TIDX_W-1:0] prod_reg;
    logic              hit_p_reg;
    logic [COL_W-1:0]  col_p_reg;
    logic [ROW_W-1:0]  row_p_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= TIDX_W'(row_s_reg) * TIDX_W'(cols_eff);
            hit_p_reg <= hit_s_reg;
            col_p_reg <= col_s_reg;
            row_p_reg <= row_s_reg;
        end
    end

    // output register
    logic              hit_o_reg;
    logic [COL_W-1:0]  col_o_reg;
    logic [ROW_W-1:0]  row_o_reg;
    logic [TIDX_W-1:0] tile_index_o_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_o_reg        <= hit_p_reg;
            col_o_reg        <= col_p_reg;
            row_o_reg        <= row_p_reg;
            tile_index_o_reg <= prod_reg + TIDX_W'(col_p_reg);
        end
    end

    assign result.valid      = valid_reg[PIPE_DEPTH-1];
    assign result.hit        = hit_o_reg;
    assign result.col        = col_o_reg;
    assign result.row        = row_o_reg;
    assign result.tile_index = tile_index_o_reg;

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |->
            result.col == '0 && result.row == '0 && result.tile_index == '0)
        else $error("miss transaction with nonzero fields");

    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |->
            result.tile_index == TIDX_W'(TIDX_W'(result.row) * TIDX_W'(cols_eff)
                                         + TIDX_W'(result.col)))
        else $error("tile_index does not match row and col");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |->
            {1'b0, result.col} < cols_eff && {1'b0, result.row} < rows_eff)
        else $error("hit outside the map");

    a_hit_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |->
            tile_width_reg != '0 && tile_height_reg != '0)
        else $error("hit with zero tile size");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !query.ready |-> result.valid && !result.ready)
        else $error("query stalled without output backpressure");
`endif

endmodule

`default_nettype wire
